// File: hdl/gga_pkg.sv
// Shared types, constants and constant tables for the GGA sentence parser.
// Used by every module of the block; depends on nothing else.
package gga_pkg;

	// Number of decimal fraction digits kept for the minutes of an angle.
	localparam int MINUTE_FRAC_DIGITS = 5;

	// Field widths of one beat.
	localparam int CHAR_W  = 8;
	localparam int TIME_W  = 27;
	localparam int LAT_W   = 31;
	localparam int LON_W   = 32;
	localparam int QUAL_W  = 3;
	localparam int SAT_W   = 7;
	localparam int FIELD_W = 4;
	localparam int POS_W   = 5;
	localparam int MAG_W   = LON_W + 1;

	// Packing of the result payload, first field in the lowest bits.
	localparam int OFS_TIME  = 0;
	localparam int OFS_LAT   = OFS_TIME + TIME_W;
	localparam int OFS_LON   = OFS_LAT + LAT_W;
	localparam int OFS_QUAL  = OFS_LON + LON_W;
	localparam int OFS_SAT   = OFS_QUAL + QUAL_W;
	localparam int PAYLOAD_W = OFS_SAT + SAT_W;
	localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
	localparam int TUSER_W   = 1;

	// Field numbers within a sentence.
	localparam logic [FIELD_W-1:0] FLD_TALKER = 4'd0;
	localparam logic [FIELD_W-1:0] FLD_TIME   = 4'd1;
	localparam logic [FIELD_W-1:0] FLD_LAT    = 4'd2;
	localparam logic [FIELD_W-1:0] FLD_NS     = 4'd3;
	localparam logic [FIELD_W-1:0] FLD_LON    = 4'd4;
	localparam logic [FIELD_W-1:0] FLD_EW     = 4'd5;
	localparam logic [FIELD_W-1:0] FLD_QUAL   = 4'd6;
	localparam logic [FIELD_W-1:0] FLD_SATS   = 4'd7;
	localparam logic [FIELD_W-1:0] FLD_LAST   = 4'd14;
	localparam logic [FIELD_W-1:0] FLD_MAX    = 4'd15;

	// Character positions inside a field.
	localparam logic [POS_W-1:0] POS_MAX      = 5'd31;
	localparam logic [POS_W-1:0] TALKER_LEN   = 5'd6;
	localparam logic [POS_W-1:0] TIME_DOT_POS = 5'd6;
	localparam logic [POS_W-1:0] TIME_MIN_LEN = 5'd8;
	localparam logic [POS_W-1:0] TIME_WEIGHTED = 5'd10;
	localparam logic [POS_W-1:0] LAT_DEG      = 5'd2;
	localparam logic [POS_W-1:0] LON_DEG      = 5'd3;

	// Characters.
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
	localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
	localparam logic [CHAR_W-1:0] CH_W     = 8'h57;

	// Range limits.
	localparam logic [TIME_W-1:0] DAY_MS    = 27'd86400000;
	localparam logic [MAG_W-1:0]  LAT_LIMIT = 33'd900000000;
	localparam logic [MAG_W-1:0]  LON_LIMIT = 33'd1800000000;
	localparam logic [QUAL_W-1:0] QUAL_MAX  = 3'd6;
	localparam logic [QUAL_W-1:0] QUAL_SAT  = 3'd7;
	localparam logic [SAT_W-1:0]  SAT_SAT   = 7'd99;

	// Integer power, used only at elaboration.
	function automatic longint unsigned ipow(input int b, input int n);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * longint'(b);
		end
		return r;
	endfunction

	// Minutes are held scaled by 10^F and range below 60 minutes.
	localparam longint unsigned MIN_MAX = 6 * ipow(10, MINUTE_FRAC_DIGITS + 1);
	localparam int MIN_W = $clog2(MIN_MAX);

	// Minutes to 1e-7 degree: q = floor((2*NUM*m + DEN) / (2*DEN)), the ratio
	// 1e7 / (60 * 10^F) reduced by its common factors of two and five.
	localparam int G2 = (MINUTE_FRAC_DIGITS + 2 < 7) ? MINUTE_FRAC_DIGITS + 2 : 7;
	localparam int G5 = (MINUTE_FRAC_DIGITS + 1 < 7) ? MINUTE_FRAC_DIGITS + 1 : 7;
	localparam longint unsigned CONV_NUM = ipow(2, 7 - G2) * ipow(5, 7 - G5);
	localparam longint unsigned CONV_DEN =
		ipow(2, MINUTE_FRAC_DIGITS + 2 - G2) * 3 * ipow(5, MINUTE_FRAC_DIGITS + 1 - G5);
	localparam longint unsigned CONV_MUL = 2 * CONV_NUM;
	localparam longint unsigned CONV_DIV = 2 * CONV_DEN;
	localparam longint unsigned X_MAX = CONV_MUL * (MIN_MAX - 1) + CONV_DEN;
	localparam int X_W = $clog2(X_MAX + 1);

	// Division by CONV_DIV as a multiply by a rounded-up reciprocal.
	localparam int CONV_SHIFT = X_W + $clog2(CONV_DIV);
	localparam longint unsigned CONV_RECIP =
		((64'd1 << CONV_SHIFT) + CONV_DIV - 1) / CONV_DIV;
	localparam int RECIP_W = $clog2(CONV_RECIP + 1);
	localparam int PROD_W  = X_W + RECIP_W;
	localparam int Q_W     = $clog2(ipow(10, 7) + 1);

	// Minute weight for each position after the degree digits.
	typedef logic [MIN_W-1:0] min_weight_tab_t [2**POS_W];

	function automatic min_weight_tab_t build_min_weights();
		min_weight_tab_t t;
		for (int p = 0; p < 2**POS_W; p++) begin
			if (p == 0) begin
				t[p] = MIN_W'(ipow(10, MINUTE_FRAC_DIGITS + 1));
			end else if (p == 1) begin
				t[p] = MIN_W'(ipow(10, MINUTE_FRAC_DIGITS));
			end else if (p >= 3 && p - 3 < MINUTE_FRAC_DIGITS) begin
				t[p] = MIN_W'(ipow(10, MINUTE_FRAC_DIGITS - 1 - (p - 3)));
			end else begin
				t[p] = '0;
			end
		end
		return t;
	endfunction

	localparam min_weight_tab_t MIN_WEIGHT = build_min_weights();

	// Milliseconds per digit of hhmmss.sss; the decimal point has no weight.
	function automatic logic [TIME_W-1:0] time_weight(input logic [POS_W-1:0] p);
		logic [TIME_W-1:0] w;
		unique case (p)
			5'd0:    w = 27'd36000000;
			5'd1:    w = 27'd3600000;
			5'd2:    w = 27'd600000;
			5'd3:    w = 27'd60000;
			5'd4:    w = 27'd10000;
			5'd5:    w = 27'd1000;
			5'd7:    w = 27'd100;
			5'd8:    w = 27'd10;
			5'd9:    w = 27'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

	// Weight in 1e-7 degree of each degree digit.
	function automatic logic [LON_W-1:0] deg_weight(input logic is_lon,
			input logic [POS_W-1:0] p);
		logic [LON_W-1:0] w;
		if (is_lon) begin
			unique case (p)
				5'd0:    w = 32'd1000000000;
				5'd1:    w = 32'd100000000;
				5'd2:    w = 32'd10000000;
				default: w = '0;
			endcase
		end else begin
			unique case (p)
				5'd0:    w = 32'd100000000;
				5'd1:    w = 32'd10000000;
				default: w = '0;
			endcase
		end
		return w;
	endfunction

	// Expected talker and sentence characters "$GPGGA".
	function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] p);
		logic [CHAR_W-1:0] c;
		unique case (p)
			3'd0:    c = 8'h24;
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h50;
			3'd3:    c = 8'h47;
			3'd4:    c = 8'h47;
			3'd5:    c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Request into the minute conversion pipeline.
	typedef struct packed {
		logic             kill;
		logic             valid;
		logic             is_lon;
		logic [MIN_W-1:0] minutes;
	} conv_req_t;

	// Finished minute conversion.
	typedef struct packed {
		logic           valid;
		logic           is_lon;
		logic [Q_W-1:0] q;
	} conv_res_t;

	// One parsed sentence.
	typedef struct packed {
		logic                    ok;
		logic [TIME_W-1:0]       time_ms;
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		logic [QUAL_W-1:0]       qual;
		logic [SAT_W-1:0]        sats;
	} result_t;

endpackage

// File: hdl/nmea_gga_sentence_parser_top.sv
// A result beat is registered after its last character beat has passed the input register.
// Throughput: one character beat per cycle, set by the input register and the parse logic.
// A waiting result holds back only the last beat of the next sentence.
// Minute conversions run in a three-stage pipeline behind the parse state.
// Reset: arst_n clears all control and sentence state at once; no clearing pass follows.
// Top level of the GGA parser; depends on gga_pkg, gga_parser and gga_angle_conv.
module nmea_gga_sentence_parser_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [gga_pkg::CHAR_W-1:0]   s_tdata,  // char_in
	input  logic                         s_tlast,  // last_char
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// time_of_day_ms, latitude_e7, longitude_e7, fix_quality, satellites, zero fill
	output logic [gga_pkg::TDATA_W-1:0]  m_tdata,
	output logic [gga_pkg::TUSER_W-1:0]  m_tuser   // sentence_ok
);
	import gga_pkg::*;

	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;
	logic               out_valid_q;
	logic               ok_q;
	logic [TDATA_W-1:0] data_q;
	logic               out_free;
	logic               proc;
	logic               emit;
	conv_req_t          req;
	conv_res_t          res;
	result_t            result;

	// A character moves on unless it ends a sentence and the result slot is full.
	assign out_free = ~out_valid_q | m_tready;
	assign proc     = valid_s1 & (~last_s1 | out_free);
	assign emit     = proc & last_s1;
	assign s_tready = ~valid_s1 | proc;

	// Input register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (emit) begin
			ok_q   <= result.ok;
			data_q <= {{(TDATA_W - PAYLOAD_W){1'b0}}, result.sats, result.qual,
				result.lon, result.lat, result.time_ms};
		end
	end

	gga_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (proc),
		.char_in    (char_s1),
		.last_char  (last_s1),
		.res        (res),
		.req        (req),
		.result     (result)
	);

	gga_angle_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = data_q;
	assign m_tuser[0] = ok_q;

endmodule

// File: hdl/gga_angle_conv.sv
// Three-stage pipeline that turns scaled minutes into 1e-7 degree, rounded.
// Depends on gga_pkg for the reciprocal constants and the request types.
module gga_angle_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  gga_pkg::conv_req_t req,
	output gga_pkg::conv_res_t res
);
	import gga_pkg::*;

	localparam logic [X_W-1:0]     MUL_K   = X_W'(CONV_MUL);
	localparam logic [X_W-1:0]     ADD_K   = X_W'(CONV_DEN);
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(CONV_RECIP);

	logic               valid_s1, valid_s2, valid_s3;
	logic               lon_s1, lon_s2, lon_s3;
	logic [X_W-1:0]     x_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [Q_W-1:0]     q_s3;

	// Stage valids; a finished sentence flushes whatever is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= req.valid & ~req.kill;
			valid_s2 <= valid_s1 & ~req.kill;
			valid_s3 <= valid_s2 & ~req.kill;
		end
	end

	// Scale and bias, multiply by the reciprocal, then drop the fraction.
	always_ff @(posedge clk) begin
		x_s1    <= X_W'(req.minutes) * MUL_K + ADD_K;
		lon_s1  <= req.is_lon;
		prod_s2 <= PROD_W'(x_s1) * PROD_W'(RECIP_K);
		lon_s2  <= lon_s1;
		q_s3    <= Q_W'(prod_s2 >> CONV_SHIFT);
		lon_s3  <= lon_s2;
	end

	assign res.valid  = valid_s3;
	assign res.is_lon = lon_s3;
	assign res.q      = q_s3;

endmodule

// File: hdl/gga_parser.sv
// Sentence state and per-character parse logic of the GGA parser.
// Depends on gga_pkg; its minute conversions run in gga_angle_conv.
module gga_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic [gga_pkg::CHAR_W-1:0]  char_in,
	input  logic                        last_char,
	input  gga_pkg::conv_res_t          res,
	output gga_pkg::conv_req_t          req,
	output gga_pkg::result_t            result
);
	import gga_pkg::*;

	// Sentence state.
	logic [FIELD_W-1:0] fi_q, fi_d;
	logic [POS_W-1:0]   cp_q, cp_d;
	logic               dot_q, dot_d;
	logic               err_q, err_d;
	logic [TIME_W-1:0]  time_q, time_d;
	logic [LAT_W-1:0]   lat_q, lat_d;
	logic [LON_W-1:0]   lon_q, lon_d;
	logic [MIN_W-1:0]   min_q, min_d;
	logic               south_q, south_d;
	logic               west_q, west_d;
	logic [QUAL_W-1:0]  qual_q, qual_d;
	logic [SAT_W-1:0]   sat_q, sat_d;

	// Per-character helpers.
	logic               dig;
	logic [3:0]         d;
	logic               is_lon;
	logic [POS_W-1:0]   deg;
	logic [POS_W-1:0]   pos;
	logic [TIME_W-1:0]  time_sum;
	logic [LON_W-1:0]   ang_acc, ang_sum;
	logic [MIN_W-1:0]   min_sum;
	logic [6:0]         qual_sum;
	logic [9:0]         sat_sum;
	logic [LON_W-1:0]   res_acc;
	logic [MAG_W-1:0]   mag;
	logic               over_limit;
	logic               clear;
	logic               ok;
	logic [LAT_W-1:0]   lat_neg;
	logic [LON_W-1:0]   lon_neg;

	assign dig      = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign d        = char_in[3:0];
	assign is_lon   = (fi_q == FLD_LON);
	assign deg      = is_lon ? LON_DEG : LAT_DEG;
	assign pos      = cp_q - deg;
	assign time_sum = time_q + TIME_W'(d) * time_weight(cp_q);
	assign ang_acc  = is_lon ? lon_q : {1'b0, lat_q};
	assign ang_sum  = ang_acc + LON_W'(d) * deg_weight(is_lon, cp_q);
	assign min_sum  = min_q + MIN_W'(MIN_W'(d) * MIN_WEIGHT[pos]);
	assign qual_sum = 7'(qual_q) * 7'd10 + 7'(d);
	assign sat_sum  = 10'(sat_q) * 10'd10 + 10'(d);

	// Landing of a minute conversion: add to the degrees and check the range.
	assign res_acc    = res.is_lon ? lon_q : {1'b0, lat_q};
	assign mag        = {1'b0, res_acc} + MAG_W'(res.q);
	assign over_limit = res.is_lon ? (mag > LON_LIMIT) : (mag > LAT_LIMIT);

	assign clear = item_valid & last_char;

	// Next state for one character, plus any conversion landing this cycle.
	always_comb begin
		fi_d    = fi_q;
		cp_d    = cp_q;
		dot_d   = dot_q;
		err_d   = err_q;
		time_d  = time_q;
		lat_d   = lat_q;
		lon_d   = lon_q;
		min_d   = min_q;
		south_d = south_q;
		west_d  = west_q;
		qual_d  = qual_q;
		sat_d   = sat_q;
		req     = '0;
		req.kill    = clear;
		req.is_lon  = is_lon;
		req.minutes = min_q;

		if (item_valid) begin
			if (char_in == CH_COMMA) begin
				// End of field checks.
				case (fi_q)
					FLD_TALKER: begin
						if (cp_q != TALKER_LEN) err_d = 1'b1;
					end
					FLD_TIME: begin
						if (!dot_q || cp_q < TIME_MIN_LEN) err_d = 1'b1;
					end
					FLD_LAT, FLD_LON: begin
						if (cp_q < deg + 5'd2) begin
							err_d = 1'b1;
						end else begin
							req.valid = ~last_char;
							min_d     = '0;
						end
					end
					FLD_NS, FLD_EW: begin
						if (cp_q != 5'd1) err_d = 1'b1;
					end
					FLD_QUAL: begin
						if (cp_q == '0 || qual_q > QUAL_MAX) err_d = 1'b1;
					end
					FLD_SATS: begin
						if (cp_q == '0) err_d = 1'b1;
					end
					default: begin
					end
				endcase
				fi_d  = (fi_q == FLD_MAX) ? fi_q : fi_q + 4'd1;
				cp_d  = '0;
				dot_d = 1'b0;
			end else begin
				// Character inside a field.
				case (fi_q)
					FLD_TALKER: begin
						if (cp_q >= TALKER_LEN || char_in != prefix_char(cp_q[2:0])) begin
							err_d = 1'b1;
						end
					end
					FLD_TIME: begin
						if (cp_q == TIME_DOT_POS) begin
							if (char_in != CH_DOT) err_d = 1'b1;
							else dot_d = 1'b1;
						end else if (!dig) begin
							err_d = 1'b1;
						end else if ((cp_q == 5'd0 && d > 4'd2) ||
								((cp_q == 5'd2 || cp_q == 5'd4) && d > 4'd5)) begin
							err_d = 1'b1;
						end else if (cp_q < TIME_WEIGHTED) begin
							time_d = time_sum;
							if (cp_q == 5'd1 && time_sum >= DAY_MS) err_d = 1'b1;
						end
					end
					FLD_LAT, FLD_LON: begin
						if (cp_q < deg) begin
							if (!dig || (is_lon && cp_q == 5'd0 && d > 4'd1)) begin
								err_d = 1'b1;
							end else if (is_lon) begin
								lon_d = ang_sum;
							end else begin
								lat_d = LAT_W'(ang_sum);
							end
						end else if (cp_q == deg + 5'd2) begin
							if (char_in != CH_DOT) err_d = 1'b1;
							else dot_d = 1'b1;
						end else if (!dig || (cp_q == deg && d > 4'd5)) begin
							err_d = 1'b1;
						end else begin
							min_d = min_sum;
						end
					end
					FLD_NS: begin
						if (cp_q == '0 && char_in == CH_S) south_d = 1'b1;
						else if (!(cp_q == '0 && char_in == CH_N)) err_d = 1'b1;
					end
					FLD_EW: begin
						if (cp_q == '0 && char_in == CH_W) west_d = 1'b1;
						else if (!(cp_q == '0 && char_in == CH_E)) err_d = 1'b1;
					end
					FLD_QUAL: begin
						if (!dig) err_d = 1'b1;
						else qual_d = (qual_sum > 7'(QUAL_SAT)) ? QUAL_SAT : qual_sum[QUAL_W-1:0];
					end
					FLD_SATS: begin
						if (!dig) err_d = 1'b1;
						else sat_d = (sat_sum > 10'(SAT_SAT)) ? SAT_SAT : sat_sum[SAT_W-1:0];
					end
					default: begin
					end
				endcase
				cp_d = (cp_q == POS_MAX) ? cp_q : cp_q + 5'd1;
			end
		end

		if (res.valid) begin
			if (res.is_lon) lon_d = mag[LON_W-1:0];
			else lat_d = mag[LAT_W-1:0];
			if (over_limit) err_d = 1'b1;
		end
	end

	// State registers; the end of a sentence returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q    <= '0;
			cp_q    <= '0;
			dot_q   <= 1'b0;
			err_q   <= 1'b0;
			time_q  <= '0;
			lat_q   <= '0;
			lon_q   <= '0;
			min_q   <= '0;
			south_q <= 1'b0;
			west_q  <= 1'b0;
			qual_q  <= '0;
			sat_q   <= '0;
		end else if (clear) begin
			fi_q    <= '0;
			cp_q    <= '0;
			dot_q   <= 1'b0;
			err_q   <= 1'b0;
			time_q  <= '0;
			lat_q   <= '0;
			lon_q   <= '0;
			min_q   <= '0;
			south_q <= 1'b0;
			west_q  <= 1'b0;
			qual_q  <= '0;
			sat_q   <= '0;
		end else begin
			fi_q    <= fi_d;
			cp_q    <= cp_d;
			dot_q   <= dot_d;
			err_q   <= err_d;
			time_q  <= time_d;
			lat_q   <= lat_d;
			lon_q   <= lon_d;
			min_q   <= min_d;
			south_q <= south_d;
			west_q  <= west_d;
			qual_q  <= qual_d;
			sat_q   <= sat_d;
		end
	end

	// Result of the sentence as it stands after this character.
	assign ok      = ~err_d & (fi_d == FLD_LAST);
	assign lat_neg = '0 - lat_d;
	assign lon_neg = '0 - lon_d;

	assign result.ok      = ok;
	assign result.time_ms = ok ? time_d : '0;
	assign result.lat     = ok ? $signed(south_d ? lat_neg : lat_d) : '0;
	assign result.lon     = ok ? $signed(west_d ? lon_neg : lon_d) : '0;
	assign result.qual    = ok ? qual_d : '0;
	assign result.sats    = ok ? sat_d : '0;

endmodule

// File: hdl/gga_checker.sv
// Port-level checks for the GGA parser, bound to the top level.
// Depends on gga_pkg for the payload layout and range limits.
module gga_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [gga_pkg::TDATA_W-1:0]  m_tdata,
	input logic [gga_pkg::TUSER_W-1:0]  m_tuser
);
	import gga_pkg::*;

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A failed sentence carries an all-zero payload.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("failed sentence with nonzero payload");

	// A good sentence has time, quality and satellites in range.
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[OFS_TIME +: TIME_W] < DAY_MS &&
			m_tdata[OFS_QUAL +: QUAL_W] <= QUAL_MAX &&
			m_tdata[OFS_SAT +: SAT_W] <= SAT_SAT)
		else $error("good sentence with time, quality or satellites out of range");

	// A good sentence has latitude and longitude within their limits.
	a_ok_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			$signed(m_tdata[OFS_LAT +: LAT_W]) <= $signed(LAT_W'(LAT_LIMIT)) &&
			$signed(m_tdata[OFS_LAT +: LAT_W]) >= -$signed(LAT_W'(LAT_LIMIT)) &&
			$signed(m_tdata[OFS_LON +: LON_W]) <= $signed(LON_W'(LON_LIMIT)) &&
			$signed(m_tdata[OFS_LON +: LON_W]) >= -$signed(LON_W'(LON_LIMIT)))
		else $error("good sentence with an angle out of range");

endmodule

bind nmea_gga_sentence_parser_top gga_checker u_gga_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: dv/gga_fix_checker.sv
// Checker for the GGA sentence parser: predicts each result from the accepted character beats.
// It compares every result beat with the oldest prediction and counts the failures.
// Depends on gga_pkg for the port widths and the number of minute fraction digits.
module gga_fix_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [gga_pkg::CHAR_W-1:0]  s_tdata,  // char_in
	input  logic                        s_tlast,  // last_char
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	// time_of_day_ms, latitude_e7, longitude_e7, fix_quality, satellites, zero fill
	input  logic [gga_pkg::TDATA_W-1:0] m_tdata,
	input  logic [gga_pkg::TUSER_W-1:0] m_tuser,  // sentence_ok
	output int unsigned                 fail_count,
	output int unsigned                 pending,
	output int unsigned                 good_fixes,
	output int unsigned                 fixes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_DIGITS = gga_pkg::MINUTE_FRAC_DIGITS;
	localparam int MAX_PRINTS  = 30;

	// Field numbers within a sentence.
	localparam logic [3:0] F_TALKER = 4'd0;
	localparam logic [3:0] F_TIME   = 4'd1;
	localparam logic [3:0] F_LAT    = 4'd2;
	localparam logic [3:0] F_NS     = 4'd3;
	localparam logic [3:0] F_LON    = 4'd4;
	localparam logic [3:0] F_EW     = 4'd5;
	localparam logic [3:0] F_QUAL   = 4'd6;
	localparam logic [3:0] F_SATS   = 4'd7;
	localparam logic [3:0] F_LAST   = 4'd14;
	localparam logic [3:0] F_CAP    = 4'd15;

	// Characters the parser looks for.
	localparam logic [7:0] C_COMMA = ",";
	localparam logic [7:0] C_DOT   = ".";
	localparam logic [7:0] C_ZERO  = "0";
	localparam logic [7:0] C_NINE  = "9";
	localparam logic [7:0] C_N     = "N";
	localparam logic [7:0] C_S     = "S";
	localparam logic [7:0] C_E     = "E";
	localparam logic [7:0] C_W     = "W";
	localparam string TALKER_TXT = "$GPGGA";

	// Milliseconds carried by each character position of hhmmss.sss.
	localparam int unsigned MS_WEIGHT [10] =
		'{36000000, 3600000, 600000, 60000, 10000, 1000, 0, 100, 10, 1};

	// Layout of the result beat, first field in the lowest bits.
	localparam int TIME_LSB = 0;
	localparam int LAT_LSB  = TIME_LSB + 27;
	localparam int LON_LSB  = LAT_LSB + 31;
	localparam int QUAL_LSB = LON_LSB + 32;
	localparam int SAT_LSB  = QUAL_LSB + 3;
	localparam int PAD_LSB  = SAT_LSB + 7;

	typedef struct packed {
		logic              ok;
		logic [26:0]       ms;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic [2:0]        qual;
		logic [6:0]        sats;
	} gga_fix_t;

	// Parse state of the sentence in progress.
	logic [3:0]        fld;
	logic [4:0]        pos;
	bit                dot_seen;
	bit                bad;
	logic [26:0]       ms_acc;
	logic [30:0]       lat_mag;
	logic [31:0]       lon_mag;
	longint unsigned   min_acc;
	bit                south;
	bit                west;
	logic [2:0]        qual_acc;
	logic [6:0]        sat_acc;

	gga_fix_t    fixes_due [$];
	int unsigned errs;
	int unsigned n_good;
	int unsigned n_seen;

	function automatic longint unsigned ten_to(input int n);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		errs++;
		if (errs <= MAX_PRINTS) begin
			$display("%0t ns: result %0d: %s", $time, n_seen, what);
		end
	endtask

	task automatic clear_parse();
		fld = '0;
		pos = '0;
		dot_seen = 0;
		bad = 0;
		ms_acc = '0;
		lat_mag = '0;
		lon_mag = '0;
		min_acc = 0;
		south = 0;
		west = 0;
		qual_acc = '0;
		sat_acc = '0;
	endtask

	// One character of a latitude (two degree digits) or longitude (three).
	task automatic add_angle_char(input logic [7:0] c, input int ndeg);
		int p;
		int d;
		bit dig;
		longint unsigned step;
		p = pos;
		d = int'(c) - int'(C_ZERO);
		dig = (c >= C_ZERO && c <= C_NINE);
		if (p < ndeg) begin
			if (!dig || (ndeg == 3 && p == 0 && d > 1)) begin
				bad = 1;
			end else begin
				step = longint'(d) * ten_to(7 + ndeg - 1 - p);
				if (ndeg == 2) lat_mag = lat_mag + step;
				else lon_mag = lon_mag + step;
			end
		end else if (p < ndeg + 2) begin
			if (!dig || (p == ndeg && d > 5)) bad = 1;
			else min_acc += longint'(d) * ten_to(FRAC_DIGITS + ndeg + 1 - p);
		end else if (p == ndeg + 2) begin
			if (c != C_DOT) bad = 1;
			else dot_seen = 1;
		end else begin
			if (!dig) bad = 1;
			else if (p - ndeg - 3 < FRAC_DIGITS)
				min_acc += longint'(d) * ten_to(FRAC_DIGITS - 1 - (p - ndeg - 3));
		end
	endtask

	// Fold the minutes into the angle, rounded to nearest with halves up.
	task automatic close_angle(input int ndeg, input longint unsigned limit);
		longint unsigned den;
		longint unsigned mag;
		den = 60 * ten_to(FRAC_DIGITS);
		if (pos < ndeg + 2) begin
			bad = 1;
			return;
		end
		mag = (ndeg == 2) ? longint'(lat_mag) : longint'(lon_mag);
		mag = mag + (min_acc * 64'd10000000 + den / 2) / den;
		if (mag > limit) bad = 1;
		if (ndeg == 2) lat_mag = 31'(mag);
		else lon_mag = 32'(mag);
		min_acc = 0;
	endtask

	task automatic close_field();
		case (fld)
			F_TALKER: if (pos != 5'd6) bad = 1;
			F_TIME:   if (!dot_seen || pos < 5'd8) bad = 1;
			F_LAT:    close_angle(2, 64'd900000000);
			F_LON:    close_angle(3, 64'd1800000000);
			F_NS, F_EW, F_SATS: begin
				if (pos != 5'd1 && fld != F_SATS) bad = 1;
				if (pos == 5'd0) bad = 1;
			end
			F_QUAL:   if (pos == 5'd0 || qual_acc > 3'd6) bad = 1;
			default: ;
		endcase
	endtask

	task automatic parse_char(input logic [7:0] c);
		int p;
		int d;
		int acc;
		bit dig;
		p = pos;
		d = int'(c) - int'(C_ZERO);
		dig = (c >= C_ZERO && c <= C_NINE);
		case (fld)
			F_TALKER: if (p >= 6 || c != TALKER_TXT[p]) bad = 1;
			F_TIME: begin
				if (p == 6) begin
					if (c != C_DOT) bad = 1;
					else dot_seen = 1;
				end else if (!dig) begin
					bad = 1;
				end else if ((p == 0 && d > 2) || ((p == 2 || p == 4) && d > 5)) begin
					bad = 1;
				end else if (p < 10) begin
					ms_acc = ms_acc + 27'(d * MS_WEIGHT[p]);
					if (p == 1 && ms_acc >= 27'd86400000) bad = 1;
				end
			end
			F_LAT: add_angle_char(c, 2);
			F_LON: add_angle_char(c, 3);
			F_NS: begin
				if (p == 0 && c == C_S) south = 1;
				else if (!(p == 0 && c == C_N)) bad = 1;
			end
			F_EW: begin
				if (p == 0 && c == C_W) west = 1;
				else if (!(p == 0 && c == C_E)) bad = 1;
			end
			F_QUAL: begin
				if (!dig) begin
					bad = 1;
				end else begin
					acc = int'(qual_acc) * 10 + d;
					qual_acc = (acc > 7) ? 3'd7 : 3'(acc);
				end
			end
			F_SATS: begin
				if (!dig) begin
					bad = 1;
				end else begin
					acc = int'(sat_acc) * 10 + d;
					sat_acc = (acc > 99) ? 7'd99 : 7'(acc);
				end
			end
			default: ;
		endcase
	endtask

	// Advance the parse by one accepted character beat.
	task automatic predict_char(input logic [7:0] c, input logic last);
		gga_fix_t fix;
		if (c == C_COMMA) begin
			close_field();
			if (fld < F_CAP) fld++;
			pos = '0;
			dot_seen = 0;
		end else begin
			parse_char(c);
			if (pos < 5'd31) pos++;
		end
		if (last) begin
			close_field();
			fix = '0;
			fix.ok = !bad && fld == F_LAST;
			if (fix.ok) begin
				fix.ms = ms_acc;
				fix.lat = south ? -lat_mag : lat_mag;
				fix.lon = west ? -lon_mag : lon_mag;
				fix.qual = qual_acc;
				fix.sats = sat_acc;
			end
			fixes_due.push_back(fix);
			clear_parse();
		end
	endtask

	// Compare a result beat with the oldest prediction, field by field.
	task automatic check_fix();
		gga_fix_t got;
		gga_fix_t want;
		got.ok   = m_tuser[0];
		got.ms   = m_tdata[TIME_LSB +: 27];
		got.lat  = m_tdata[LAT_LSB +: 31];
		got.lon  = m_tdata[LON_LSB +: 32];
		got.qual = m_tdata[QUAL_LSB +: 3];
		got.sats = m_tdata[SAT_LSB +: 7];
		n_seen++;
		if (got.ok === 1'b1) n_good++;
		if (fixes_due.size() == 0) begin
			note_mismatch("result beat arrived with no sentence waiting for it");
			return;
		end
		want = fixes_due.pop_front();
		if (got.ok !== want.ok)
			note_mismatch($sformatf("sentence_ok %0b, expected %0b", got.ok, want.ok));
		if (got.ms !== want.ms)
			note_mismatch($sformatf("time_of_day_ms %0d, expected %0d", got.ms, want.ms));
		if (got.lat !== want.lat)
			note_mismatch($sformatf("latitude_e7 %0d, expected %0d", got.lat, want.lat));
		if (got.lon !== want.lon)
			note_mismatch($sformatf("longitude_e7 %0d, expected %0d", got.lon, want.lon));
		if (got.qual !== want.qual)
			note_mismatch($sformatf("fix_quality %0d, expected %0d", got.qual, want.qual));
		if (got.sats !== want.sats)
			note_mismatch($sformatf("satellites %0d, expected %0d", got.sats, want.sats));
		if ((m_tdata >> PAD_LSB) !== '0)
			note_mismatch("zero fill of the result beat is not zero");
	endtask

	// Results are checked before a new prediction is queued on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			fixes_due.delete();
			errs = 0;
			n_good = 0;
			n_seen = 0;
			fail_count <= 0;
			pending <= 0;
			good_fixes <= 0;
			fixes_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) check_fix();
			if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
			fail_count <= errs;
			pending <= fixes_due.size();
			good_fixes <= n_good;
			fixes_seen <= n_seen;
		end
	end

endmodule

// File: dv/nmea_gga_sentence_parser_top_tb.sv
// Testbench top for the GGA sentence parser: feeds directed and random sentences
// under three idle patterns and gives the verdict. Depends on gga_pkg, the parser
// top level and gga_fix_checker.
module nmea_gga_sentence_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 16;
	localparam int NOISE_PER_PHASE  = 3;
	// Sender gap and receiver stall odds in percent, one pair per phase.
	localparam int GAP_PCT [3]   = '{32, 66, 0};
	localparam int STALL_PCT [3] = '{66, 32, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [gga_pkg::CHAR_W-1:0] s_tdata = '0;   // char_in
	logic s_tlast = 1'b0;                       // last_char
	logic m_tvalid;
	logic m_tready = 1'b0;
	// time_of_day_ms, latitude_e7, longitude_e7, fix_quality, satellites, zero fill
	logic [gga_pkg::TDATA_W-1:0] m_tdata;
	logic [gga_pkg::TUSER_W-1:0] m_tuser;        // sentence_ok

	int unsigned fail_count;
	int unsigned pending;
	int unsigned good_fixes;
	int unsigned fixes_seen;

	int gap_pct = 0;
	int stall_pct = 0;
	int unsigned beats = 0;
	int unsigned sentences = 0;
	int unsigned cycles = 0;
	logic [7:0] sentence_chars [$];

	nmea_gga_sentence_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	gga_fix_checker fix_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.good_fixes (good_fixes),
		.fixes_seen (fixes_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver stalls at random with the odds of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic add_text(input string t);
		for (int i = 0; i < t.len(); i++) begin
			sentence_chars.push_back(t[i]);
		end
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++) begin
			sentence_chars.push_back(8'd48 + 8'($urandom_range(0, 9)));
		end
	endtask

	// Optional minute fraction: none, a bare point, or up to eight digits.
	task automatic add_fraction();
		int r;
		r = $urandom_range(0, 3);
		if (r == 1) begin
			add_text(".");
		end else if (r > 1) begin
			add_text(".");
			add_digits($urandom_range(1, 8));
		end
	endtask

	// One character beat; the sender may idle first with random data on the bus.
	task automatic send_beat(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom_range(0, 255));
			s_tlast <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		beats++;
	endtask

	task automatic send_sentence();
		for (int i = 0; i < sentence_chars.size(); i++) begin
			send_beat(sentence_chars[i], i == sentence_chars.size() - 1);
		end
		sentence_chars.delete();
		sentences++;
	endtask

	initial begin
		int hh;
		int mm;
		int ss;
		int deg;
		int mins;
		int n;
		int r;
		int idx;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = GAP_PCT[0];
		stall_pct = STALL_PCT[0];

		// Directed sentences: a typical fix, both range extremes, truncation
		// and saturation, syntax and range faults, field counts
		// above and below fifteen, long fields, and a one-beat sentence.
		add_text("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
		send_sentence();
		add_text("$GPGGA,235959.999,9000.00000,S,18000.00000,W,6,99,1.0,0.0,M,0.0,M,0000,*7F");
		send_sentence();
		add_text("$GPGGA,000000.0,0000,N,00000,E,0,0,,,,,,,");
		send_sentence();
		add_text("$GPGGA,092750.123456,5321.6802123,S,00630.3372,W,2,123,,,,,,,");
		send_sentence();
		add_text("$GPGGA,240000.0,9000.00001,N,18000.00001,E,1,05,,,,,,,");
		send_sentence();
		add_text("$GPGGA,126000.0,4807.,N,19131.0,E,7,08,,,,,,,");
		send_sentence();
		add_text("$GPGGB,12a519,48,NS,0113,X,,,,,,,,,");
		send_sentence();
		add_text("$GPGG,123519.,4867.0,S,21131.0,W,1,08,,,,,,,,");
		send_sentence();
		add_text("$GPGGAA,1");
		send_sentence();
		add_text("$GPGGA,,,,,,,,,,,,,,,,,,,,,1");
		send_sentence();
		add_text("$GPGGA,123519.");
		add_digits(40);
		add_text(",4807.038,N,01131.000,E,1,08,,,,,,,");
		send_sentence();
		add_text("$GPGGA,101010.5,1000.0,N,01000.0,E,3,04,");
		sentence_chars.push_back(8'hFF);
		sentence_chars.push_back(8'h00);
		sentence_chars.push_back(8'hA5);
		add_text(",,,,,,");
		send_sentence();
		add_text(",");
		send_sentence();

		// Random part: mostly well-formed sentences with random content, some
		// with a fault planted, and a little pure noise, under each idle pattern.
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = GAP_PCT[ph];
			stall_pct = STALL_PCT[ph];
			repeat (RANDOM_PER_PHASE) begin
				if ($urandom_range(0, 29) == 0) add_text("$GPGSA,");
				else add_text("$GPGGA,");
				// Time of day, now and then out of range or without a fraction.
				hh = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23);
				mm = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
				ss = $urandom_range(0, 59);
				add_text($sformatf("%02d%02d%02d", hh, mm, ss));
				if ($urandom_range(0, 19) != 0) begin
					add_text(".");
					add_digits($urandom_range(1, 6));
				end
				// Latitude, with exactly ninety degrees fairly often.
				deg = ($urandom_range(0, 9) == 0) ? 90 : $urandom_range(0, 89);
				mins = $urandom_range(0, 59);
				if (deg == 90 && $urandom_range(0, 1) == 1) mins = 0;
				if ($urandom_range(0, 19) == 0) mins = $urandom_range(60, 99);
				add_text($sformatf("%02d%02d", deg, mins));
				add_fraction();
				add_text(($urandom_range(0, 1) == 1) ? ",N," : ",S,");
				// Longitude, with 180 degrees and a bad hundreds digit now and then.
				r = $urandom_range(0, 29);
				if (r < 3) deg = 180;
				else if (r == 3) deg = $urandom_range(200, 299);
				else deg = $urandom_range(0, 179);
				mins = $urandom_range(0, 59);
				if (deg == 180 && $urandom_range(0, 1) == 1) mins = 0;
				add_text($sformatf("%03d%02d", deg, mins));
				add_fraction();
				add_text(($urandom_range(0, 1) == 1) ? ",E," : ",W,");
				// Fix quality, now and then above six or missing.
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
				if ($urandom_range(0, 39) != 0) begin
					if ($urandom_range(0, 3) == 0) add_text($sformatf("%02d", n));
					else add_text($sformatf("%0d", n));
				end
				add_text(",");
				// Satellites, past the saturation point at times.
				n = $urandom_range(0, 150);
				if ($urandom_range(0, 3) == 0) add_text($sformatf("%03d", n));
				else add_text($sformatf("%0d", n));
				// The seven trailing fields are free text without commas.
				for (int f = 0; f < 7; f++) begin
					add_text(",");
					r = $urandom_range(0, 4);
					if (r == 1) begin
						add_digits($urandom_range(1, 3));
						add_text(".");
						add_digits(1);
					end else if (r == 2) begin
						add_text("M");
					end else if (r == 3) begin
						add_text($sformatf("*%02X", $urandom_range(0, 255)));
					end else if (r == 4) begin
						repeat ($urandom_range(1, 3)) begin
							n = $urandom_range(33, 126);
							if (n == 44) n = 45;
							sentence_chars.push_back(8'(n));
						end
					end
				end
				// One sentence in five gets a fault planted somewhere.
				if ($urandom_range(0, 4) == 0) begin
					idx = $urandom_range(0, sentence_chars.size() - 1);
					case ($urandom_range(0, 3))
						0: sentence_chars[idx] = 8'($urandom_range(0, 255));
						1: sentence_chars.delete(idx);
						2: sentence_chars.insert(idx, 8'h2C);
						default: begin
							n = $urandom_range(1, sentence_chars.size() - 1);
							while (sentence_chars.size() > n) sentence_chars.pop_back();
						end
					endcase
				end
				send_sentence();
			end
			// Short bursts of arbitrary bytes.
			repeat (NOISE_PER_PHASE) begin
				repeat ($urandom_range(1, 12)) begin
					sentence_chars.push_back(8'($urandom_range(0, 255)));
				end
				send_sentence();
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		// Let the last results drain, then allow for the pipeline latency.
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d sentences in %0d character beats under three idle patterns.",
			sentences, beats);
		$display("Checked %0d results, %0d of them valid fixes; %0d mismatches.",
			fixes_seen, good_fixes, fail_count);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/gga_pkg.sv
hdl/gga_angle_conv.sv
hdl/gga_parser.sv
hdl/nmea_gga_sentence_parser_top.sv
hdl/gga_checker.sv
dv/gga_fix_checker.sv
dv/nmea_gga_sentence_parser_top_tb.sv
